FILE: design/ste_pkg.sv
// ----------------------------------------------------------------------------
// Synapse table engine package
// Shared codes, command classification and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ste_pkg;

  localparam logic [2:0] ACT_CREATE   = 3'd0;
  localparam logic [2:0] ACT_REMOVE   = 3'd1;
  localparam logic [2:0] ACT_DELIVER  = 3'd2;
  localparam logic [2:0] ACT_MODULATE = 3'd3;
  localparam logic [2:0] ACT_INCIDENT = 3'd4;
  localparam logic [2:0] ACT_RESET    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic REG_WEIGHT_FLOOR   = 1'b0;
  localparam logic REG_WEIGHT_CEILING = 1'b1;

  localparam logic signed [15:0] WEIGHT_FLOOR_RESET   = 16'sh8000;
  localparam logic signed [15:0] WEIGHT_CEILING_RESET = 16'sh7FFF;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_REMOVE,
    OP_DELIVER,
    OP_MODULATE,
    OP_INCIDENT,
    OP_CLEAR,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] status;
  } cmd_ctl_t;

  typedef struct packed {
    logic               strobe;
    logic [1:0]         status;
    logic               delivered;
    logic [15:0]        target;
    logic signed [15:0] weight;
    logic [6:0]         total;
    logic               last;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/ste_regs.sv
// ----------------------------------------------------------------------------
// Synapse table engine configuration registers
// APB-style register file holding the weight clamp bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ste_regs import ste_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output logic signed [15:0]      weight_floor,
  output logic signed [15:0]      weight_ceiling
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_floor   <= WEIGHT_FLOOR_RESET;
      weight_ceiling <= WEIGHT_CEILING_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WEIGHT_FLOOR:   weight_floor   <= pwdata[15:0];
        REG_WEIGHT_CEILING: weight_ceiling <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WEIGHT_FLOOR:   prdata = 32'(weight_floor);
      REG_WEIGHT_CEILING: prdata = 32'(weight_ceiling);
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ste_front.sv
// ----------------------------------------------------------------------------
// Synapse table engine front end
// Accepts commands, classifies the action and formats the queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ste_front import ste_pkg::*; #(
  parameter int NEURON_ID_BITS = 16,
  parameter int WEIGHT_BITS    = 16
) (
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           action,
  input  wire logic [15:0]          source_neuron,
  input  wire logic [15:0]          target_neuron,
  input  wire logic signed [15:0]   new_weight,
  input  wire logic signed [15:0]   modulation,
  input  wire logic                 q_full,
  output logic                      push,
  output logic [$bits(cmd_ctl_t)+2*NEURON_ID_BITS+WEIGHT_BITS+16-1:0] push_data
);

  localparam int IW = (NEURON_ID_BITS > 16) ? NEURON_ID_BITS : 16;
  localparam int XW = (WEIGHT_BITS > 16) ? WEIGHT_BITS : 16;

  cmd_ctl_t                  ctl;
  logic [IW-1:0]             src_ext;
  logic [IW-1:0]             tgt_ext;
  logic signed [XW-1:0]      nw_ext;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    case (action)
      ACT_CREATE:   ctl = '{op: OP_CREATE,   status: ST_FULL};
      ACT_REMOVE:   ctl = '{op: OP_REMOVE,   status: ST_NOT_FOUND};
      ACT_DELIVER:  ctl = '{op: OP_DELIVER,  status: ST_OK};
      ACT_MODULATE: ctl = '{op: OP_MODULATE, status: ST_OK};
      ACT_INCIDENT: ctl = '{op: OP_INCIDENT, status: ST_OK};
      ACT_RESET:    ctl = '{op: OP_CLEAR,    status: ST_OK};
      default:      ctl = '{op: OP_UNKNOWN,  status: ST_NOT_FOUND};
    endcase
  end

  assign src_ext = IW'(source_neuron);
  assign tgt_ext = IW'(target_neuron);
  assign nw_ext  = XW'(new_weight);

  assign push_data = {ctl, src_ext[NEURON_ID_BITS-1:0], tgt_ext[NEURON_ID_BITS-1:0],
                      nw_ext[WEIGHT_BITS-1:0], modulation};

endmodule

`default_nettype wire

FILE: design/ste_queue.sv
// ----------------------------------------------------------------------------
// Synapse table engine command queue
// Short FIFO that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ste_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/ste_back.sv
// ----------------------------------------------------------------------------
// Synapse table engine back end
// Scans the synapse table one slot per cycle and produces the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ste_back import ste_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int NEURON_ID_BITS = 16,
  parameter int WEIGHT_BITS    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_empty,
  input  wire logic [$bits(cmd_ctl_t)+2*NEURON_ID_BITS+WEIGHT_BITS+16-1:0] q_data,
  output logic                      pop,
  input  wire logic signed [15:0]   weight_floor,
  input  wire logic signed [15:0]   weight_ceiling,
  output result_t                   result
);

  localparam int NB   = NEURON_ID_BITS;
  localparam int WB   = WEIGHT_BITS;
  localparam int CTLW = $bits(cmd_ctl_t);
  localparam int QW   = CTLW + 2 * NB + WB + 16;
  localparam int EW   = 2 * NB + WB;
  localparam int IDXW = $clog2(TABLE_SLOTS);
  localparam int CNTW = $clog2(TABLE_SLOTS + 1);
  localparam int IW   = (NB > 16) ? NB : 16;
  localparam int XW   = (WB > 16) ? WB : 16;
  localparam int SUMW = XW + 1;
  localparam logic [CNTW-1:0] SLOT_COUNT = CNTW'(TABLE_SLOTS);
  localparam logic [IDXW-1:0] LAST_SLOT  = IDXW'(TABLE_SLOTS - 1);

  back_state_t          state;
  back_state_t          state_next;
  cmd_ctl_t             head_ctl;
  op_t                  cmd_op;
  logic [NB-1:0]        cmd_src;
  logic [NB-1:0]        cmd_tgt;
  logic [WB-1:0]        cmd_nw;
  logic signed [15:0]   cmd_mod;
  logic [1:0]           status_acc;

  logic [EW-1:0]        mem [TABLE_SLOTS];
  logic [EW-1:0]        rd_entry;
  logic [TABLE_SLOTS-1:0] valid;
  logic [CNTW-1:0]      live_count;
  logic [CNTW-1:0]      rptr;
  logic                 s1_valid;
  logic [IDXW-1:0]      s1_slot;

  logic                 pend;
  logic [15:0]          pend_target;
  logic signed [15:0]   pend_weight;

  logic                 issue;
  logic                 check;
  logic                 slot_on;
  logic                 src_hit;
  logic                 tgt_hit;
  logic                 inc_hit;
  logic                 take_free;
  logic                 take_rm;
  logic                 take_inc;
  logic                 take_dlv;
  logic                 take_mod;
  logic                 scan_stop;
  logic                 head_scans;

  logic [NB-1:0]        rd_src;
  logic [NB-1:0]        rd_tgt;
  logic signed [WB-1:0] rd_w;
  logic [IW-1:0]        rd_tgt_ext;
  logic signed [XW-1:0] rd_w_ext;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] hi_bound;
  logic signed [SUMW-1:0] lo_bound;
  logic signed [SUMW-1:0] clamp_hi;
  logic signed [SUMW-1:0] clamp_lo;
  logic                 mem_we;
  logic [EW-1:0]        mem_wdata;

  assign head_ctl   = cmd_ctl_t'(q_data[QW-1 -: CTLW]);
  assign head_scans = (head_ctl.op != OP_CLEAR) && (head_ctl.op != OP_UNKNOWN);

  assign rd_src     = rd_entry[EW-1 -: NB];
  assign rd_tgt     = rd_entry[WB +: NB];
  assign rd_w       = rd_entry[WB-1:0];
  assign rd_tgt_ext = IW'(rd_tgt);
  assign rd_w_ext   = XW'(rd_w);

  assign check   = (state == BK_SCAN) && s1_valid;
  assign slot_on = valid[s1_slot];
  assign src_hit = (rd_src == cmd_src);
  assign tgt_hit = (rd_tgt == cmd_tgt);
  assign inc_hit = (rd_tgt == cmd_src);

  assign take_free = check && (cmd_op == OP_CREATE) && !slot_on;
  assign take_rm   = check && (cmd_op == OP_REMOVE) && slot_on && src_hit && tgt_hit;
  assign take_inc  = check && (cmd_op == OP_INCIDENT) && slot_on && (src_hit || inc_hit);
  assign take_dlv  = check && (cmd_op == OP_DELIVER) && slot_on && src_hit;
  assign take_mod  = check && (cmd_op == OP_MODULATE) && slot_on;
  assign scan_stop = check && (take_free || take_rm || (s1_slot == LAST_SLOT));

  assign sum      = SUMW'(rd_w) + SUMW'(cmd_mod);
  assign hi_bound = SUMW'(weight_ceiling);
  assign lo_bound = SUMW'(weight_floor);
  assign clamp_hi = (sum > hi_bound) ? hi_bound : sum;
  assign clamp_lo = (clamp_hi < lo_bound) ? lo_bound : clamp_hi;

  assign mem_we    = take_free || take_mod;
  assign mem_wdata = take_free ? {cmd_src, cmd_tgt, cmd_nw}
                               : {rd_src, rd_tgt, clamp_lo[WB-1:0]};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = head_scans ? BK_SCAN : BK_FINISH;
        end
      end
      BK_SCAN: begin
        if (scan_stop) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    case (state)
      BK_IDLE: pop   = !q_empty;
      BK_SCAN: issue = (rptr < SLOT_COUNT);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[s1_slot] <= mem_wdata;
    end
    if (issue) begin
      rd_entry <= mem[rptr[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_op  <= head_ctl.op;
      cmd_src <= q_data[QW-CTLW-1 -: NB];
      cmd_tgt <= q_data[WB+16 +: NB];
      cmd_nw  <= q_data[16 +: WB];
      cmd_mod <= q_data[15:0];
    end
    if (issue) begin
      s1_slot <= rptr[IDXW-1:0];
    end
    if (take_dlv) begin
      pend_target <= rd_tgt_ext[15:0];
      pend_weight <= rd_w_ext[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_IDLE;
      valid         <= '0;
      live_count    <= '0;
      rptr          <= '0;
      s1_valid      <= 1'b0;
      pend          <= 1'b0;
      status_acc    <= ST_OK;
      result.strobe <= 1'b0;
    end else begin
      state         <= state_next;
      s1_valid      <= issue;
      result.strobe <= 1'b0;
      if (pop) begin
        status_acc <= head_ctl.status;
        rptr       <= '0;
        pend       <= 1'b0;
      end
      if (issue) begin
        rptr <= rptr + CNTW'(1);
      end
      if (take_free) begin
        valid[s1_slot] <= 1'b1;
        live_count     <= live_count + CNTW'(1);
        status_acc     <= ST_OK;
      end
      if (take_rm || take_inc) begin
        valid[s1_slot] <= 1'b0;
        live_count     <= live_count - CNTW'(1);
      end
      if (take_rm) begin
        status_acc <= ST_OK;
      end
      if (take_dlv) begin
        pend <= 1'b1;
        if (pend) begin
          result.strobe    <= 1'b1;
          result.status    <= ST_OK;
          result.delivered <= 1'b1;
          result.target    <= pend_target;
          result.weight    <= pend_weight;
          result.total     <= 7'(live_count);
          result.last      <= 1'b0;
        end
      end
      if (state == BK_FINISH) begin
        result.strobe    <= 1'b1;
        result.status    <= status_acc;
        result.delivered <= pend;
        result.target    <= pend ? pend_target : '0;
        result.weight    <= pend ? pend_weight : '0;
        result.total     <= (cmd_op == OP_CLEAR) ? '0 : 7'(live_count);
        result.last      <= 1'b1;
        if (cmd_op == OP_CLEAR) begin
          valid      <= '0;
          live_count <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/synapse_table_engine_core.sv
// ----------------------------------------------------------------------------
// Synapse table engine
// Fixed-capacity synapse table with create, remove, spike delivery,
// weight modulation, incident removal and clear actions.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; a two-entry queue
// lets up to two commands wait while the engine works. Create, remove,
// deliver, modulate and remove incident scan the table one slot per cycle
// through the table memory's single read port; create ends early at its
// first free slot and remove at its first match. Clear and unknown actions
// skip the scan. Results come out one per cycle at most, each for exactly
// one cycle with strobe high, and the receiver cannot stall them; last
// marks the final result of a command and every result carries the
// synapse total after that command.
`timescale 1ns / 1ps
`default_nettype none

module synapse_table_engine_core import ste_pkg::*; #(
  parameter int TABLE_SLOTS    = 64,
  parameter int NEURON_ID_BITS = 16,
  parameter int WEIGHT_BITS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         action,
  input  wire logic [15:0]        source_neuron,
  input  wire logic [15:0]        target_neuron,
  input  wire logic signed [15:0] new_weight,
  input  wire logic signed [15:0] modulation,
  output logic                    strobe,
  output logic [1:0]              status,
  output logic                    delivered,
  output logic [15:0]             out_target,
  output logic signed [15:0]      out_weight,
  output logic [6:0]              synapse_total,
  output logic                    last,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int QW = $bits(cmd_ctl_t) + 2 * NEURON_ID_BITS + WEIGHT_BITS + 16;

  logic signed [15:0] weight_floor;
  logic signed [15:0] weight_ceiling;
  logic               q_full;
  logic               q_empty;
  logic               push;
  logic               pop;
  logic [QW-1:0]      push_data;
  logic [QW-1:0]      q_data;
  result_t            result;

  ste_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .weight_floor   (weight_floor),
    .weight_ceiling (weight_ceiling)
  );

  ste_front #(
    .NEURON_ID_BITS (NEURON_ID_BITS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .action        (action),
    .source_neuron (source_neuron),
    .target_neuron (target_neuron),
    .new_weight    (new_weight),
    .modulation    (modulation),
    .q_full        (q_full),
    .push          (push),
    .push_data     (push_data)
  );

  ste_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  ste_back #(
    .TABLE_SLOTS    (TABLE_SLOTS),
    .NEURON_ID_BITS (NEURON_ID_BITS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_data),
    .pop            (pop),
    .weight_floor   (weight_floor),
    .weight_ceiling (weight_ceiling),
    .result         (result)
  );

  assign strobe        = result.strobe;
  assign status        = result.status;
  assign delivered     = result.delivered;
  assign out_target    = result.target;
  assign out_weight    = result.weight;
  assign synapse_total = result.total;
  assign last          = result.last;

endmodule

`default_nettype wire

FILE: design/ste_checker.sv
// ----------------------------------------------------------------------------
// Synapse table engine checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ste_checker import ste_pkg::*; #(
  parameter int TABLE_SLOTS = 64
) (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       strobe,
  input wire logic [1:0] status,
  input wire logic       delivered,
  input wire logic [6:0] synapse_total,
  input wire logic       last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("result transfer right after reset");

  a_plain_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !delivered) |-> last)
    else $error("result without a delivered synapse is not final");

  a_delivered_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && delivered) |-> (status == ST_OK))
    else $error("delivered synapse with non-ok status");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_FULL)) |-> (synapse_total == 7'(TABLE_SLOTS)))
    else $error("table full reported with free slots");

endmodule

bind synapse_table_engine_core ste_checker #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_ste_checker (
  .clk           (clk),
  .rst           (rst),
  .strobe        (strobe),
  .status        (status),
  .delivered     (delivered),
  .synapse_total (synapse_total),
  .last          (last)
);

`default_nettype wire

FILE: test/tb_synapse_table_engine_core.sv
// ----------------------------------------------------------------------------
// Synapse table engine testbench
// Drives create, remove, deliver, modulate, incident, clear and unknown
// commands into the engine, predicts every result from a table model of
// its own and checks the result stream field by field under three clamp
// settings and three sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_synapse_table_engine_core;
  import ste_pkg::*;

  localparam int SLOTS       = 64;
  localparam int TAIL_CYCLES = 72;
  localparam int STALL_LIMIT = 2000;

  localparam logic [2:0] ACT_SPARE_LOW  = 3'd6;
  localparam logic [2:0] ACT_SPARE_HIGH = 3'd7;
  localparam logic [2:0] ADDR_WEIGHT_FLOOR   = {REG_WEIGHT_FLOOR, 2'b00};
  localparam logic [2:0] ADDR_WEIGHT_CEILING = {REG_WEIGHT_CEILING, 2'b00};

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        src;
    logic [15:0]        tgt;
    logic signed [15:0] weight;
    logic signed [15:0] level;
  } synapse_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] action = '0;
  logic [15:0] source_neuron = '0;
  logic [15:0] target_neuron = '0;
  logic signed [15:0] new_weight = '0;
  logic signed [15:0] modulation = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;

  logic busy;
  logic strobe;
  logic [1:0] status;
  logic delivered;
  logic [15:0] out_target;
  logic signed [15:0] out_weight;
  logic [6:0] synapse_total;
  logic last;
  logic [31:0] prdata;
  logic pready;

  synapse_table_engine_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .source_neuron(source_neuron), .target_neuron(target_neuron),
    .new_weight(new_weight), .modulation(modulation),
    .strobe(strobe), .status(status), .delivered(delivered),
    .out_target(out_target), .out_weight(out_weight),
    .synapse_total(synapse_total), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  synapse_cmd_t command_backlog[$];
  result_t      synapse_results_due[$];
  synapse_cmd_t cmd_on_port;
  int           send_idle_pct = 0;
  int           fault_count = 0;
  int           result_index = 0;
  int           quiet_cycles = 0;

  logic               slot_valid[SLOTS];
  logic [15:0]        slot_source[SLOTS];
  logic [15:0]        slot_target[SLOTS];
  logic signed [15:0] slot_weight[SLOTS];
  int                 live_total = 0;
  logic signed [15:0] clamp_low = WEIGHT_FLOOR_RESET;
  logic signed [15:0] clamp_high = WEIGHT_CEILING_RESET;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_source[i] = '0;
      slot_target[i] = '0;
      slot_weight[i] = '0;
    end
  end

  task automatic report_fault(input string msg);
    $display("FAULT at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  function automatic void table_action(input synapse_cmd_t c);
    result_t r;
    int hits;
    int k;
    int w;
    logic done;
    r = '0;
    r.strobe = 1'b1;
    r.status = ST_OK;
    r.last = 1'b1;
    hits = 0;
    k = 0;
    done = 1'b0;
    case (c.action)
      ACT_CREATE: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_valid[i] && !done) begin
            slot_valid[i] = 1'b1;
            slot_source[i] = c.src;
            slot_target[i] = c.tgt;
            slot_weight[i] = c.weight;
            live_total++;
            r.status = ST_OK;
            done = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && !done && slot_source[i] == c.src && slot_target[i] == c.tgt) begin
            slot_valid[i] = 1'b0;
            live_total--;
            r.status = ST_OK;
            done = 1'b1;
          end
        end
      end
      ACT_DELIVER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_source[i] == c.src) hits++;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && slot_source[i] == c.src) begin
            k++;
            r.delivered = 1'b1;
            r.target = slot_target[i];
            r.weight = slot_weight[i];
            r.total = live_total[6:0];
            r.last = (k == hits);
            synapse_results_due.push_back(r);
          end
        end
      end
      ACT_MODULATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i]) begin
            w = int'(slot_weight[i]) + int'(c.level);
            if (w > int'(clamp_high)) w = int'(clamp_high);
            if (w < int'(clamp_low)) w = int'(clamp_low);
            slot_weight[i] = w[15:0];
          end
        end
      end
      ACT_INCIDENT: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_valid[i] && (slot_source[i] == c.src || slot_target[i] == c.src)) begin
            slot_valid[i] = 1'b0;
            live_total--;
          end
        end
      end
      ACT_RESET: begin
        for (int i = 0; i < SLOTS; i++) slot_valid[i] = 1'b0;
        live_total = 0;
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    if (hits == 0) begin
      r.total = live_total[6:0];
      synapse_results_due.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) table_action(cmd_on_port);
      if (start && busy) begin
        start <= 1'b1;
      end else if (command_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd_on_port = command_backlog.pop_front();
        start <= 1'b1;
        action <= cmd_on_port.action;
        source_neuron <= cmd_on_port.src;
        target_neuron <= cmd_on_port.tgt;
        new_weight <= cmd_on_port.weight;
        modulation <= cmd_on_port.level;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t due;
    if (!rst && strobe) begin
      if (synapse_results_due.size() == 0) begin
        report_fault($sformatf("result %0d arrived with nothing outstanding", result_index));
      end else begin
        due = synapse_results_due.pop_front();
        if (status !== due.status)
          report_fault($sformatf("result %0d status %0d, expected %0d",
                                 result_index, status, due.status));
        if (delivered !== due.delivered)
          report_fault($sformatf("result %0d delivered %0d, expected %0d",
                                 result_index, delivered, due.delivered));
        if (out_target !== due.target)
          report_fault($sformatf("result %0d out_target %0d, expected %0d",
                                 result_index, out_target, due.target));
        if (out_weight !== due.weight)
          report_fault($sformatf("result %0d out_weight %0d, expected %0d",
                                 result_index, out_weight, due.weight));
        if (synapse_total !== due.total)
          report_fault($sformatf("result %0d synapse_total %0d, expected %0d",
                                 result_index, synapse_total, due.total));
        if (last !== due.last)
          report_fault($sformatf("result %0d last %0d, expected %0d",
                                 result_index, last, due.last));
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_clamp(input logic [2:0] addr, input logic signed [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_WEIGHT_FLOOR) clamp_low = value;
    else clamp_high = value;
  endtask

  task automatic queue_cmd(input logic [2:0] act, input logic [15:0] src,
                           input logic [15:0] tgt, input logic [15:0] wt,
                           input logic [15:0] lvl);
    synapse_cmd_t c;
    c.action = act;
    c.src = src;
    c.tgt = tgt;
    c.weight = wt;
    c.level = lvl;
    command_backlog.push_back(c);
  endtask

  function automatic logic [15:0] pick_neuron();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'($urandom_range(0, 3));
    if (r < 88) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'h7FFF;
    if (r < 30) return 16'h8000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 600) - 300);
    if (r < 50) return 16'h7FFF;
    if (r < 60) return 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic queue_random_cmd(input logic [2:0] act);
    logic [15:0] src;
    logic [15:0] tgt;
    src = 16'($urandom);
    tgt = 16'($urandom);
    if (act == ACT_CREATE || act == ACT_REMOVE || act == ACT_DELIVER || act == ACT_INCIDENT)
      src = pick_neuron();
    if (act == ACT_CREATE || act == ACT_REMOVE) tgt = pick_neuron();
    queue_cmd(act, src, tgt, pick_weight(), pick_level());
  endtask

  // A full table is only reached by an unbroken run of creates, so each
  // random phase fills the table past capacity around one hub neuron.
  task automatic queue_random_phase(input int hub_share, input int mixed_count);
    logic [15:0] hub;
    int r;
    hub = 16'($urandom_range(0, 3));
    queue_random_cmd(ACT_RESET);
    for (int i = 0; i < SLOTS + 4; i++) begin
      if ($urandom_range(0, 99) < hub_share)
        queue_cmd(ACT_CREATE, hub, pick_neuron(), pick_weight(), 16'($urandom));
      else
        queue_random_cmd(ACT_CREATE);
    end
    queue_cmd(ACT_DELIVER, hub, 16'($urandom), 16'($urandom), 16'($urandom));
    queue_random_cmd(ACT_MODULATE);
    queue_cmd(ACT_DELIVER, hub, 16'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < mixed_count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 38) queue_random_cmd(ACT_CREATE);
      else if (r < 52) queue_random_cmd(ACT_REMOVE);
      else if (r < 72) queue_random_cmd(ACT_DELIVER);
      else if (r < 82) queue_random_cmd(ACT_MODULATE);
      else if (r < 90) queue_random_cmd(ACT_INCIDENT);
      else if (r < 92) queue_random_cmd(ACT_RESET);
      else if (r < 96) queue_random_cmd(ACT_SPARE_LOW);
      else queue_random_cmd(ACT_SPARE_HIGH);
    end
  endtask

  task automatic drain_results();
    do @(negedge clk);
    while (command_backlog.size() != 0 || start || synapse_results_due.size() != 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_clamp(ADDR_WEIGHT_FLOOR, 16'sh8000);
    write_clamp(ADDR_WEIGHT_CEILING, 16'sh7FFF);
    @(negedge clk);

    send_idle_pct = 18;
    queue_cmd(ACT_DELIVER, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_CREATE, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    queue_cmd(ACT_CREATE, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF);
    queue_cmd(ACT_CREATE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_CREATE, 16'h0000, 16'h0005, 16'hFFFF, 16'h0000);
    queue_cmd(ACT_DELIVER, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(ACT_MODULATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    queue_cmd(ACT_DELIVER, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_MODULATE, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
    queue_cmd(ACT_DELIVER, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_MODULATE, 16'h0000, 16'h0000, 16'h0000, 16'h0005);
    queue_cmd(ACT_REMOVE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    queue_cmd(ACT_REMOVE, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    queue_cmd(ACT_DELIVER, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_CREATE, 16'h0000, 16'h0005, 16'h0007, 16'h0000);
    queue_cmd(ACT_REMOVE, 16'h0000, 16'h0005, 16'h0000, 16'h0000);
    queue_cmd(ACT_DELIVER, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_INCIDENT, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_INCIDENT, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_SPARE_LOW, 16'h1234, 16'h4321, 16'h1111, 16'h2222);
    queue_cmd(ACT_SPARE_HIGH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cmd(ACT_CREATE, 16'h00AA, 16'h0055, 16'h0100, 16'h0000);
    queue_cmd(ACT_RESET, 16'h00AA, 16'h0000, 16'h0000, 16'h0000);
    queue_cmd(ACT_INCIDENT, 16'h00AA, 16'h0000, 16'h0000, 16'h0000);
    queue_random_phase(100, 32);
    drain_results();

    write_clamp(ADDR_WEIGHT_FLOOR, -16'sd1000);
    write_clamp(ADDR_WEIGHT_CEILING, 16'sd1000);
    @(negedge clk);
    send_idle_pct = 58;
    queue_random_phase(70, 32);
    drain_results();

    write_clamp(ADDR_WEIGHT_FLOOR, 16'sd500);
    write_clamp(ADDR_WEIGHT_CEILING, -16'sd500);
    @(negedge clk);
    send_idle_pct = 0;
    queue_random_phase(50, 32);
    drain_results();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
